>>> rtl/core/suie_pkg.sv
// Package for the set union / intersection engine.
// Holds the payload structs, sizing constants, FSM state and phase types,
// and the controller/datapath command and status structs. No dependencies.
`timescale 1ns / 1ps

package suie_pkg;

   localparam int SET_DEPTH = 32;
   localparam int ADDR_W    = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
   localparam int COUNT_W   = $clog2(SET_DEPTH + 1);
   localparam int VALUE_W   = 32;

   typedef enum logic {
      MODE_UNION = 1'b0,
      MODE_INTER = 1'b1
   } mode_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] element_value;
      logic                      into_second;
      logic                      finish;
   } req_type;

   typedef struct packed {
      logic signed [VALUE_W-1:0] result_value;
      logic                      last_item;
      logic                      empty_result;
      logic                      overflowed;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_OUT_RD,
      S_OUT_LAT,
      S_SCAN,
      S_KEEP,
      S_FLUSH
   } state_type;

   typedef enum logic [1:0] {
      PH_COPY,
      PH_UNION_B,
      PH_INTER
   } phase_type;

   // controller -> datapath
   typedef struct packed {
      logic load;          // store the accepted load transaction
      logic outer_start;   // restart outer index
      logic outer_second;  // outer walk runs over the second store
      logic outer_read;    // read outer entry, advance outer index, restart scan
      logic cand_load;     // capture outer read data as candidate
      logic inner_step;    // issue one inner read and fold previous compare
      logic keep;          // candidate is a result
      logic flush;         // close the run: last item out, clear counts
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic     outer_done;
      logic     scan_done;
      logic     matched;
      logic     out_free;
      mode_type mode;
   } status_type;

endpackage

>>> rtl/core/suie_ctrl.sv
// Controller FSM for the set union / intersection engine.
// Sequences the outer walk, inner scan, result hand-off and run flush.
// Depends on suie_pkg.
`timescale 1ns / 1ps

module suie_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic                req_finish,
   output logic                req_stall,
   input  suie_pkg::status_type st,
   output suie_pkg::cmd_type    cmd
);
   import suie_pkg::*;

   state_type state_ff, state_in;
   phase_type phase_ff, phase_in;
   logic      emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= PH_COPY;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in         = state_ff;
      phase_in         = phase_ff;
      cmd              = '0;
      cmd.outer_second = (phase_ff == PH_UNION_B);
      emit             = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (req_finish) begin
                  cmd.outer_start = 1'b1;
                  phase_in        = (st.mode == MODE_INTER) ? PH_INTER : PH_COPY;
                  state_in        = S_OUT_RD;
               end else begin
                  cmd.load = 1'b1;
               end
            end
         end
         S_OUT_RD: begin
            if (st.outer_done) begin
               if (phase_ff == PH_COPY) begin
                  // first store copied out, now walk the second store
                  phase_in        = PH_UNION_B;
                  cmd.outer_start = 1'b1;
               end else begin
                  state_in = S_FLUSH;
               end
            end else begin
               cmd.outer_read = 1'b1;
               state_in       = S_OUT_LAT;
            end
         end
         S_OUT_LAT: begin
            cmd.cand_load = 1'b1;
            state_in      = (phase_ff == PH_COPY) ? S_KEEP : S_SCAN;
         end
         S_SCAN: begin
            cmd.inner_step = 1'b1;
            if (st.matched || st.scan_done) begin
               emit     = (phase_ff == PH_INTER) ? st.matched : !st.matched;
               state_in = emit ? S_KEEP : S_OUT_RD;
            end
         end
         S_KEEP: begin
            if (st.out_free) begin
               cmd.keep = 1'b1;
               state_in = S_OUT_RD;
            end
         end
         S_FLUSH: begin
            if (st.out_free) begin
               cmd.flush = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

>>> rtl/core/suie_dpath.sv
// Datapath for the set union / intersection engine.
// Two set stores, counts, walk indexes, candidate compare, pending result
// and the output register. Depends on suie_pkg.
`timescale 1ns / 1ps

module suie_dpath (
   input  logic                clock,
   input  logic                reset,
   input  suie_pkg::req_type    req_data,
   input  logic                csr_wr_en,
   input  logic                csr_wr_data,
   input  suie_pkg::cmd_type    cmd,
   output suie_pkg::status_type st,
   output logic                rsp_valid,
   output suie_pkg::rsp_type    rsp_data,
   input  logic                rsp_stall
);
   import suie_pkg::*;

   logic [VALUE_W-1:0] mem_first  [SET_DEPTH];
   logic [VALUE_W-1:0] mem_second [SET_DEPTH];

   logic [VALUE_W-1:0] rd_first_ff, rd_second_ff;
   logic [ADDR_W-1:0]  addr_first, addr_second;

   logic [COUNT_W-1:0] cnt1_ff, cnt1_in, cnt2_ff, cnt2_in;
   logic               ovf_ff, ovf_in;
   mode_type           mode_ff, mode_in;
   logic [COUNT_W-1:0] outer_idx_ff, outer_idx_in, inner_idx_ff, inner_idx_in;
   logic               cmp_valid_ff, cmp_valid_in, match_ff, match_in;
   logic [VALUE_W-1:0] cand_ff, cand_in, pend_ff, pend_in;
   logic               pend_valid_ff, pend_valid_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   logic [COUNT_W-1:0] n_outer, n_inner;
   logic [VALUE_W-1:0] inner_data;
   logic               inner_more, hit, out_free;
   logic               wr_first, wr_second;

   assign n_outer    = cmd.outer_second ? cnt2_ff : cnt1_ff;
   assign n_inner    = cmd.outer_second ? cnt1_ff : cnt2_ff;
   assign inner_data = cmd.outer_second ? rd_first_ff : rd_second_ff;
   assign inner_more = (inner_idx_ff != n_inner);
   assign hit        = cmp_valid_ff && (inner_data == cand_ff);
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   assign addr_first  = cmd.outer_second ? inner_idx_ff[ADDR_W-1:0]
                                         : outer_idx_ff[ADDR_W-1:0];
   assign addr_second = cmd.outer_second ? outer_idx_ff[ADDR_W-1:0]
                                         : inner_idx_ff[ADDR_W-1:0];

   assign wr_first  = cmd.load && !req_data.into_second && (cnt1_ff < COUNT_W'(SET_DEPTH));
   assign wr_second = cmd.load &&  req_data.into_second && (cnt2_ff < COUNT_W'(SET_DEPTH));

   // store write ports at the fill count, registered reads at the walk indexes
   always_ff @(posedge clock) begin
      if (wr_first) begin
         mem_first[cnt1_ff[ADDR_W-1:0]] <= req_data.element_value;
      end
      rd_first_ff <= mem_first[addr_first];
   end

   always_ff @(posedge clock) begin
      if (wr_second) begin
         mem_second[cnt2_ff[ADDR_W-1:0]] <= req_data.element_value;
      end
      rd_second_ff <= mem_second[addr_second];
   end

   always_comb begin
      cnt1_in       = cnt1_ff;
      cnt2_in       = cnt2_ff;
      ovf_in        = ovf_ff;
      mode_in       = mode_ff;
      outer_idx_in  = outer_idx_ff;
      inner_idx_in  = inner_idx_ff;
      cmp_valid_in  = 1'b0;
      match_in      = match_ff;
      cand_in       = cand_ff;
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_data_in   = rsp_data_ff;

      if (csr_wr_en) begin
         mode_in = mode_type'(csr_wr_data);
      end

      if (wr_first) begin
         cnt1_in = cnt1_ff + COUNT_W'(1);
      end
      if (wr_second) begin
         cnt2_in = cnt2_ff + COUNT_W'(1);
      end
      if (cmd.load && !wr_first && !wr_second) begin
         ovf_in = 1'b1;
      end

      if (cmd.outer_start) begin
         outer_idx_in = '0;
      end
      if (cmd.outer_read) begin
         outer_idx_in = outer_idx_ff + COUNT_W'(1);
         inner_idx_in = '0;
         match_in     = 1'b0;
      end
      if (cmd.cand_load) begin
         cand_in = cmd.outer_second ? rd_second_ff : rd_first_ff;
      end
      if (cmd.inner_step) begin
         match_in     = match_ff || hit;
         cmp_valid_in = inner_more;
         if (inner_more) begin
            inner_idx_in = inner_idx_ff + COUNT_W'(1);
         end
      end

      // one result is held back so the final one can carry last_item
      if (cmd.keep) begin
         if (pend_valid_ff) begin
            rsp_valid_in             = 1'b1;
            rsp_data_in.result_value = pend_ff;
            rsp_data_in.last_item    = 1'b0;
            rsp_data_in.empty_result = 1'b0;
            rsp_data_in.overflowed   = ovf_ff;
         end
         pend_in       = cand_ff;
         pend_valid_in = 1'b1;
      end

      if (cmd.flush) begin
         rsp_valid_in             = 1'b1;
         rsp_data_in.result_value = pend_valid_ff ? pend_ff : '0;
         rsp_data_in.last_item    = 1'b1;
         rsp_data_in.empty_result = !pend_valid_ff;
         rsp_data_in.overflowed   = ovf_ff;
         pend_valid_in            = 1'b0;
         cnt1_in                  = '0;
         cnt2_in                  = '0;
         ovf_in                   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt1_ff       <= '0;
         cnt2_ff       <= '0;
         ovf_ff        <= 1'b0;
         mode_ff       <= MODE_UNION;
         outer_idx_ff  <= '0;
         inner_idx_ff  <= '0;
         cmp_valid_ff  <= 1'b0;
         match_ff      <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt1_ff       <= cnt1_in;
         cnt2_ff       <= cnt2_in;
         ovf_ff        <= ovf_in;
         mode_ff       <= mode_in;
         outer_idx_ff  <= outer_idx_in;
         inner_idx_ff  <= inner_idx_in;
         cmp_valid_ff  <= cmp_valid_in;
         match_ff      <= match_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cand_ff     <= cand_in;
      pend_ff     <= pend_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign st.outer_done = (outer_idx_ff == n_outer);
   assign st.scan_done  = !inner_more && !cmp_valid_ff;
   assign st.matched    = match_ff || hit;
   assign st.out_free   = out_free;
   assign st.mode       = mode_ff;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> rtl/core/set_union_intersection_engine_unit.sv
// Set union / intersection engine: load transactions fill two 32-entry stores
// while req_stall stays low; entries past capacity are dropped and flagged as
// overflowed on the run's results. A finish transaction walks the stores
// through their single registered read ports: each outer element is read and,
// unless union is copying the first store, compared with the other store until
// a match or its end; a kept element waits for a free output register, so the
// run also waits out rsp_stall. req_stall is high for the run.
// The final result carries last_item; an empty answer gives one empty_result item.
// Top level; depends on suie_pkg, suie_ctrl and suie_dpath.
`timescale 1ns / 1ps

module set_union_intersection_engine_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  suie_pkg::req_type  req_data,
   output logic              req_stall,
   output logic              rsp_valid,
   output suie_pkg::rsp_type  rsp_data,
   input  logic              rsp_stall,
   input  logic              csr_wr_en,
   input  logic              csr_wr_data
);
   import suie_pkg::*;

   cmd_type    cmd;
   status_type st;

   suie_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_finish (req_data.finish),
      .req_stall  (req_stall),
      .st         (st),
      .cmd        (cmd)
   );

   suie_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .st          (st),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .rsp_stall   (rsp_stall)
   );

endmodule

>>> rtl/core/suie_checker.sv
// Port-level checker for the set union / intersection engine, bound to the top.
// Depends on suie_pkg and set_union_intersection_engine_unit.
`timescale 1ns / 1ps

module suie_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input suie_pkg::req_type  req_data,
   input logic              req_stall,
   input logic              rsp_valid,
   input suie_pkg::rsp_type  rsp_data,
   input logic              rsp_stall
);
   import suie_pkg::*;

   // nothing in flight after reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // an empty answer is always the single, final item of its run
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.empty_result |-> rsp_data.last_item)
      else $error("empty result without last_item");

   // a finish transaction starts a run that blocks further input
   a_finish_blocks: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_data.finish |=> req_stall)
      else $error("input not stalled after finish");

endmodule

bind set_union_intersection_engine_unit suie_checker u_suie_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_data  (req_data),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data),
   .rsp_stall (rsp_stall)
);
